>>> hw/rtl/srbb_pkg.sv
// Shared types and constants for the skin region bounding box unit.
// Depends on nothing; every other file of the block but srbb_stream_if imports it.
`default_nettype none

package srbb_pkg;

  localparam int POS_W       = 10;  // column and row counters
  localparam int DIM_W       = 11;  // frame dimensions and box minimum corner
  localparam int COUNT_W     = 19;
  localparam int SIDE_W      = 10;
  localparam int CFG_DATA_W  = 19;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST    = DIM_W'(320);
  localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST   = DIM_W'(240);
  localparam logic [COUNT_W-1:0] MIN_SKIN_COUNT_RST = COUNT_W'(100);
  localparam logic [SIDE_W-1:0]  MIN_BOX_SIDE_RST   = SIDE_W'(20);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [POS_W-1:0]   POS_MAX   = '1;

  // Skin color rule thresholds on 8-bit channels.
  localparam logic [7:0] SKIN_R_MIN  = 8'd95;
  localparam logic [7:0] SKIN_G_MIN  = 8'd40;
  localparam logic [7:0] SKIN_B_MIN  = 8'd20;
  localparam logic [7:0] SKIN_RG_GAP = 8'd15;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_MIN_SKIN_COUNT = 2'd2,
    CFG_MIN_BOX_SIDE   = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [COUNT_W-1:0] min_skin_count;
    logic [SIDE_W-1:0]  min_box_side;
  } cfg_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        frame_start;
    logic        frame_end;
  } pixel_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]   box_min_x;
    logic [DIM_W-1:0]   box_min_y;
    logic [POS_W-1:0]   box_max_x;
    logic [POS_W-1:0]   box_max_y;
    logic [SIDE_W-1:0]  box_width;
    logic [SIDE_W-1:0]  box_height;
    logic [COUNT_W-1:0] skin_count;
    logic               face_present;
  } box_item_t;

  // One classified pixel on its way from front to back.
  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             hit;
    logic             frame_start;
    logic             frame_end;
  } entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/srbb_stream_if.sv
// Valid/ready stream channel carrying one payload per request.
// Payload type is set at instantiation; no other dependencies.
`default_nettype none

interface srbb_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/skin_region_bounding_box_unit.sv
// Top level of the skin region bounding box unit: config registers, front,
// queue and back. Depends on srbb_pkg, srbb_stream_if, srbb_front,
// srbb_queue and srbb_back.
//
//   channel     dir  payload        request moves
//   pixel_in    in   pixel_item_t   one RGB565 pixel with frame_start/frame_end
//   box_out     out  box_item_t     one box result, on each frame_end pixel
//   cfg_*       in   19-bit data    one register write, index 0..3
//
// Flow: one pixel per clock while the queue has room. A frame_end pixel's result
// passes through the queue and then the back end's output register before it
// shows on box_out; its pop into that register waits while box_out still
// holds an earlier result that has not been taken.
// Reset: rst clears position, queue and output valid; registers return to
// 320/240/100/20 and trackers to the cleared state.
// Stalls: the back end holds only a frame_end entry while box_out is still
// occupied; the 4-entry queue lets pixels keep coming meanwhile, and
// pixel_in.ready drops only once the queue fills.
`default_nettype none

module skin_region_bounding_box_unit #(
  parameter int QUEUE_DEPTH = srbb_pkg::QUEUE_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  srbb_stream_if.sink                               pixel_in,
  srbb_stream_if.source                             box_out,
  input  wire logic                                 cfg_write,
  input  wire srbb_pkg::cfg_index_e                 cfg_index,
  input  wire logic [srbb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import srbb_pkg::*;

  cfg_t        cfg;
  logic        push;
  entry_t      push_entry;
  logic        queue_ready;
  logic        pop;
  logic        pop_valid;
  entry_t      pop_entry;
  logic        front_ready;
  box_item_t   box_item;
  logic        box_valid;

  // Register writes must land only while the block is idle; the user is bound to this, no guard enforces it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width    <= FRAME_WIDTH_RST;
      cfg.frame_height   <= FRAME_HEIGHT_RST;
      cfg.min_skin_count <= MIN_SKIN_COUNT_RST;
      cfg.min_box_side   <= MIN_BOX_SIDE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:    cfg.frame_width    <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:   cfg.frame_height   <= cfg_data[DIM_W-1:0];
        CFG_MIN_SKIN_COUNT: cfg.min_skin_count <= cfg_data[COUNT_W-1:0];
        CFG_MIN_BOX_SIDE:   cfg.min_box_side   <= cfg_data[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: place and classify each pixel, push it into the queue.
  srbb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (pixel_in.valid),
    .in_item     (pixel_in.payload),
    .in_ready    (front_ready),
    .queue_ready (queue_ready),
    .push        (push),
    .push_entry  (push_entry)
  );

  assign pixel_in.ready = front_ready;

  // Queue: decouple pixel intake from result delivery.
  srbb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (queue_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  // Back: advance the trackers, drop one result per frame into box_out.
  srbb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .entry_valid (pop_valid),
    .entry       (pop_entry),
    .pop         (pop),
    .out_valid   (box_valid),
    .out_item    (box_item),
    .out_ready   (box_out.ready)
  );

  assign box_out.valid   = box_valid;
  assign box_out.payload = box_item;

endmodule

`default_nettype wire

>>> hw/rtl/srbb_front.sv
// Front end: accepts pixels, tracks raster position, classifies skin samples.
// Depends on srbb_pkg; feeds srbb_queue.
`default_nettype none

module srbb_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire srbb_pkg::cfg_t       cfg,
  input  wire logic                 in_valid,
  input  wire srbb_pkg::pixel_item_t in_item,
  output logic                      in_ready,
  input  wire logic                 queue_ready,
  output logic                      push,
  output srbb_pkg::entry_t          push_entry
);
  import srbb_pkg::*;

  logic [POS_W-1:0] column;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] column_next;
  logic [POS_W-1:0] row_next;
  logic [POS_W-1:0] col_cur;
  logic [POS_W-1:0] row_cur;
  logic             row_done;
  logic             in_frame;
  logic             skin;
  logic [4:0]       r5;
  logic [5:0]       g6;
  logic [4:0]       b5;
  logic [7:0]       r8;
  logic [7:0]       g8;
  logic [7:0]       b8;

  assign in_ready = queue_ready;
  assign push     = in_valid && queue_ready;

  // Frame start restarts position before this pixel is placed.
  assign col_cur = in_item.frame_start ? '0 : column;
  assign row_cur = in_item.frame_start ? '0 : row;

  assign r5 = in_item.pixel[15:11];
  assign g6 = in_item.pixel[10:5];
  assign b5 = in_item.pixel[4:0];
  assign r8 = {r5, r5[4:2]};
  assign g8 = {g6, g6[5:4]};
  assign b8 = {b5, b5[4:2]};

  assign skin = (r8 > SKIN_R_MIN) && (g8 > SKIN_G_MIN) && (b8 > SKIN_B_MIN)
             && (r8 > g8) && (r8 > b8) && ((r8 - g8) > SKIN_RG_GAP);

  assign in_frame = ({1'b0, col_cur} < cfg.frame_width)
                 && ({1'b0, row_cur} < cfg.frame_height);

  assign row_done = (({1'b0, col_cur} + DIM_W'(1)) >= cfg.frame_width)
                 || (col_cur == POS_MAX);

  always_comb begin
    push_entry.column      = col_cur;
    push_entry.row         = row_cur;
    push_entry.hit         = !col_cur[0] && !row_cur[0] && in_frame && skin;
    push_entry.frame_start = in_item.frame_start;
    push_entry.frame_end   = in_item.frame_end;
  end

  always_comb begin
    if (in_item.frame_end) begin
      column_next = '0;
      row_next    = '0;
    end else if (row_done) begin
      column_next = '0;
      row_next    = row_cur + POS_W'(1);
    end else begin
      column_next = col_cur + POS_W'(1);
      row_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (push) begin
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/srbb_queue.sv
// Short FIFO of classified pixels between front and back.
// Depends on srbb_pkg.
`default_nettype none

module srbb_queue #(
  parameter int DEPTH = srbb_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire srbb_pkg::entry_t push_entry,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic                  pop_valid,
  output srbb_pkg::entry_t      pop_entry
);
  import srbb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not advance on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

>>> hw/rtl/srbb_back.sv
// Back end: updates the skin box trackers and registers one result per frame.
// Depends on srbb_pkg; drains srbb_queue.
`default_nettype none

module srbb_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire srbb_pkg::cfg_t    cfg,
  input  wire logic              entry_valid,
  input  wire srbb_pkg::entry_t  entry,
  output logic                   pop,
  output logic                   out_valid,
  output srbb_pkg::box_item_t    out_item,
  input  wire logic              out_ready
);
  import srbb_pkg::*;

  logic [DIM_W-1:0]   track_min_x;
  logic [DIM_W-1:0]   track_min_y;
  logic [POS_W-1:0]   track_max_x;
  logic [POS_W-1:0]   track_max_y;
  logic [COUNT_W-1:0] count_skin;

  logic [DIM_W-1:0]   base_min_x;
  logic [DIM_W-1:0]   base_min_y;
  logic [POS_W-1:0]   base_max_x;
  logic [POS_W-1:0]   base_max_y;
  logic [COUNT_W-1:0] base_count;

  logic [DIM_W-1:0]   upd_min_x;
  logic [DIM_W-1:0]   upd_min_y;
  logic [POS_W-1:0]   upd_max_x;
  logic [POS_W-1:0]   upd_max_y;
  logic [COUNT_W-1:0] upd_count;

  logic [DIM_W-1:0]   diff_x;
  logic [DIM_W-1:0]   diff_y;
  logic [SIDE_W-1:0]  width;
  logic [SIDE_W-1:0]  height;
  box_item_t          result;

  // Hold a frame-end entry until the output register can take it.
  assign pop = entry_valid && (!entry.frame_end || !out_valid || out_ready);

  always_comb begin
    if (entry.frame_start) begin
      base_min_x = cfg.frame_width;
      base_min_y = cfg.frame_height;
      base_max_x = '0;
      base_max_y = '0;
      base_count = '0;
    end else begin
      base_min_x = track_min_x;
      base_min_y = track_min_y;
      base_max_x = track_max_x;
      base_max_y = track_max_y;
      base_count = count_skin;
    end
  end

  always_comb begin
    upd_min_x = base_min_x;
    upd_min_y = base_min_y;
    upd_max_x = base_max_x;
    upd_max_y = base_max_y;
    upd_count = base_count;
    if (entry.hit) begin
      if ({1'b0, entry.column} < base_min_x) upd_min_x = {1'b0, entry.column};
      if ({1'b0, entry.row} < base_min_y)    upd_min_y = {1'b0, entry.row};
      if (entry.column > base_max_x)         upd_max_x = entry.column;
      if (entry.row > base_max_y)            upd_max_y = entry.row;
      if (base_count != COUNT_MAX)           upd_count = base_count + COUNT_W'(1);
    end
  end

  assign diff_x = {1'b0, upd_max_x} - upd_min_x;
  assign diff_y = {1'b0, upd_max_y} - upd_min_y;
  assign width  = ({1'b0, upd_max_x} > upd_min_x) ? diff_x[SIDE_W-1:0] : '0;
  assign height = ({1'b0, upd_max_y} > upd_min_y) ? diff_y[SIDE_W-1:0] : '0;

  always_comb begin
    result.box_min_x    = upd_min_x;
    result.box_min_y    = upd_min_y;
    result.box_max_x    = upd_max_x;
    result.box_max_y    = upd_max_y;
    result.box_width    = width;
    result.box_height   = height;
    result.skin_count   = upd_count;
    result.face_present = (upd_count > cfg.min_skin_count)
                       && (width > cfg.min_box_side)
                       && (height > cfg.min_box_side);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_min_x <= FRAME_WIDTH_RST;
      track_min_y <= FRAME_HEIGHT_RST;
      track_max_x <= '0;
      track_max_y <= '0;
      count_skin  <= '0;
    end else if (pop) begin
      if (entry.frame_end) begin
        track_min_x <= cfg.frame_width;
        track_min_y <= cfg.frame_height;
        track_max_x <= '0;
        track_max_y <= '0;
        count_skin  <= '0;
      end else begin
        track_min_x <= upd_min_x;
        track_min_y <= upd_min_y;
        track_max_x <= upd_max_x;
        track_max_y <= upd_max_y;
        count_skin  <= upd_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && entry.frame_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.frame_end) begin
      out_item <= result;
    end
  end

  a_width_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.box_width == '0)
               || ({1'b0, out_item.box_max_x} > out_item.box_min_x))
    else $error("box width set with max not above min");

  a_face_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.face_present |-> out_item.skin_count > cfg.min_skin_count)
    else $error("face flagged with too few skin samples");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    pop && entry.frame_end |=> count_skin == '0 && track_max_x == '0)
    else $error("trackers not cleared after frame end");

endmodule

`default_nettype wire

>>> tb/tb_skin_region_bounding_box_unit.sv
// Self-checking testbench for skin_region_bounding_box_unit: drives RGB565 frames,
// predicts each box result and compares it field by field at box_out.
// Depends on srbb_pkg, srbb_stream_if and the RTL of the unit.

import srbb_pkg::*;

// Tracks position, box corners and skin count of the current frame, and holds
// the box results still owed by the unit, oldest first.
class face_box_tracker;
  cfg_t               regs;
  logic [POS_W-1:0]   col;
  logic [POS_W-1:0]   row;
  logic [DIM_W-1:0]   min_x;
  logic [DIM_W-1:0]   min_y;
  logic [POS_W-1:0]   max_x;
  logic [POS_W-1:0]   max_y;
  logic [COUNT_W-1:0] skin_cnt;
  box_item_t          pending_boxes[$];
  int                 errors;

  function new();
    regs.frame_width    = FRAME_WIDTH_RST;
    regs.frame_height   = FRAME_HEIGHT_RST;
    regs.min_skin_count = MIN_SKIN_COUNT_RST;
    regs.min_box_side   = MIN_BOX_SIDE_RST;
    errors = 0;
    restart_frame();
  endfunction

  // Corners start from the frame size as it stands at the moment of the clear.
  function void restart_frame();
    col      = '0;
    row      = '0;
    min_x    = regs.frame_width;
    min_y    = regs.frame_height;
    max_x    = '0;
    max_y    = '0;
    skin_cnt = '0;
  endfunction

  function void write_reg(cfg_index_e idx, logic [CFG_DATA_W-1:0] wdata);
    case (idx)
      CFG_FRAME_WIDTH:    regs.frame_width    = wdata[DIM_W-1:0];
      CFG_FRAME_HEIGHT:   regs.frame_height   = wdata[DIM_W-1:0];
      CFG_MIN_SKIN_COUNT: regs.min_skin_count = wdata[COUNT_W-1:0];
      CFG_MIN_BOX_SIDE:   regs.min_box_side   = wdata[SIDE_W-1:0];
      default: ;
    endcase
  endfunction

  // Widen each channel to 8 bits by repeating its top bits, then apply the rule.
  function bit skin_tone(logic [15:0] px);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = {px[15:11], px[15:13]};
    g = {px[10:5], px[10:9]};
    b = {px[4:0], px[4:2]};
    return r > SKIN_R_MIN && g > SKIN_G_MIN && b > SKIN_B_MIN && r > g && r > b
           && (r - g) > SKIN_RG_GAP;
  endfunction

  function void take_pixel(pixel_item_t it);
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    box_item_t        box;
    if (it.frame_start)
      restart_frame();
    if (!col[0] && !row[0] && DIM_W'(col) < regs.frame_width
        && DIM_W'(row) < regs.frame_height && skin_tone(it.pixel)) begin
      if (DIM_W'(col) < min_x) min_x = DIM_W'(col);
      if (DIM_W'(row) < min_y) min_y = DIM_W'(row);
      if (col > max_x) max_x = col;
      if (row > max_y) max_y = row;
      if (skin_cnt != COUNT_MAX) skin_cnt = skin_cnt + COUNT_W'(1);
    end
    // Wrap at the frame width or at the top of the counter, whichever first.
    if (({1'b0, col} + 11'd1) >= regs.frame_width || col == POS_MAX) begin
      col = '0;
      row = row + POS_W'(1);
    end else begin
      col = col + POS_W'(1);
    end
    if (it.frame_end) begin
      w = (DIM_W'(max_x) > min_x) ? DIM_W'(max_x) - min_x : '0;
      h = (DIM_W'(max_y) > min_y) ? DIM_W'(max_y) - min_y : '0;
      box.box_min_x    = min_x;
      box.box_min_y    = min_y;
      box.box_max_x    = max_x;
      box.box_max_y    = max_y;
      box.box_width    = SIDE_W'(w);
      box.box_height   = SIDE_W'(h);
      box.skin_count   = skin_cnt;
      box.face_present = skin_cnt > regs.min_skin_count
                         && w > DIM_W'(regs.min_box_side)
                         && h > DIM_W'(regs.min_box_side);
      pending_boxes.push_back(box);
      restart_frame();
    end
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_box(box_item_t got);
    box_item_t want;
    if (pending_boxes.size() == 0) begin
      $error("box result with no frame_end request waiting for it");
      errors++;
      return;
    end
    want = pending_boxes.pop_front();
    check_field("box_min_x", 32'(want.box_min_x), 32'(got.box_min_x));
    check_field("box_min_y", 32'(want.box_min_y), 32'(got.box_min_y));
    check_field("box_max_x", 32'(want.box_max_x), 32'(got.box_max_x));
    check_field("box_max_y", 32'(want.box_max_y), 32'(got.box_max_y));
    check_field("box_width", 32'(want.box_width), 32'(got.box_width));
    check_field("box_height", 32'(want.box_height), 32'(got.box_height));
    check_field("skin_count", 32'(want.skin_count), 32'(got.skin_count));
    check_field("face_present", 32'(want.face_present), 32'(got.face_present));
  endfunction
endclass

module tb_skin_region_bounding_box_unit;

  localparam int RANDOM_ITEMS     = 970;
  localparam int STALL_LIMIT      = 2000;  // cycles with no request moving on either side
  localparam int SETTLE_CYCLES    = QUEUE_DEPTH + 4;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write;
  cfg_index_e            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srbb_stream_if #(.data_t(pixel_item_t)) pixel_in ();
  srbb_stream_if #(.data_t(box_item_t))   box_out ();

  face_box_tracker tracker = new();

  int pixels_sent  = 0;  // pixel requests accepted by the unit
  int quiet_cycles = 0;
  bit steady_phase = 1'b0;  // when set, the sender never pauses

  skin_region_bounding_box_unit dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .box_out   (box_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor and watchdog. Handshakes are read at the edge, before the unit's
  // registers update, so both sides see the same request.
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_in.valid && pixel_in.ready)
        tracker.take_pixel(pixel_in.payload);
      if (box_out.valid && box_out.ready)
        tracker.check_box(box_out.payload);
      if ((pixel_in.valid && pixel_in.ready) || (box_out.valid && box_out.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_skin_region_bounding_box_unit: FAIL");
        $finish;
      end
    end
  end

  // Result side: hold ready high or low for random stretches. Mostly short
  // flips, now and then a long stall or a long stretch with no stall at all.
  initial begin
    int hold;
    int roll;
    hold = 0;
    box_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          box_out.ready <= 1'b1;
          hold = $urandom_range(0, 6);
        end else if (roll < 65) begin
          box_out.ready <= 1'b1;
          hold = $urandom_range(40, 150);
        end else if (roll < 92) begin
          box_out.ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          box_out.ready <= 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  // Mostly back-to-back requests, some short pauses, a few long ones.
  function automatic int sender_gap();
    int roll;
    if (steady_phase)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] skin_color();
    logic [15:0] px;
    do px = 16'($urandom); while (!tracker.skin_tone(px));
    return px;
  endfunction

  // Present one pixel request and hold it until the unit takes it. Valid stays
  // high across back-to-back requests; drop it only for a pause.
  task automatic send_pixel(pixel_item_t it);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      pixel_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_in.valid   <= 1'b1;
    pixel_in.payload <= it;
    do @(posedge clk); while (!pixel_in.ready);
    pixels_sent++;
  endtask

  // Send npix pixels in raster order, the last one marked frame_end.
  task automatic send_frame(int npix, int skin_pct, bit mark_start);
    pixel_item_t it;
    for (int i = 0; i < npix; i++) begin
      it.pixel       = ($urandom_range(0, 99) < skin_pct) ? skin_color() : 16'($urandom);
      it.frame_start = mark_start && (i == 0);
      it.frame_end   = (i == npix - 1);
      send_pixel(it);
    end
  endtask

  task automatic send_one(logic [15:0] px, bit start, bit stop);
    pixel_item_t it;
    it.pixel       = px;
    it.frame_start = start;
    it.frame_end   = stop;
    send_pixel(it);
  endtask

  // Idle the sender, wait for every owed box, then give the queue and back
  // end time to empty of pixels that produce no box.
  task automatic settle();
    pixel_in.valid <= 1'b0;
    do @(negedge clk); while (tracker.pending_boxes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the registers selected in pick, one per cycle, then drop the enable.
  task automatic apply_settings(cfg_t s, logic [3:0] pick);
    cfg_index_e            idx;
    logic [CFG_DATA_W-1:0] wdata;
    for (int i = 0; i < 4; i++) begin
      if (pick[i]) begin
        idx = cfg_index_e'(i);
        case (idx)
          CFG_FRAME_WIDTH:    wdata = CFG_DATA_W'(s.frame_width);
          CFG_FRAME_HEIGHT:   wdata = CFG_DATA_W'(s.frame_height);
          CFG_MIN_SKIN_COUNT: wdata = CFG_DATA_W'(s.min_skin_count);
          default:            wdata = CFG_DATA_W'(s.min_box_side);
        endcase
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= wdata;
        @(posedge clk);
        tracker.write_reg(idx, wdata);
      end
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    cfg_t        s;
    pixel_item_t it;
    int          rand_base;
    int          fw;
    int          fh;
    int          npix;
    int          roll;
    int          tweak;
    pixel_in.valid   <= 1'b0;
    pixel_in.payload <= '0;
    cfg_write        <= 1'b0;
    cfg_index        <= CFG_FRAME_WIDTH;
    cfg_data         <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings 320x240: a lone skin pixel that both
    // starts and ends a frame, white and black pixels, an end without a start.
    send_one({5'd31, 6'd20, 5'd8}, 1'b1, 1'b1);
    send_one(16'hFFFF, 1'b1, 1'b1);
    send_one(16'h0000, 1'b0, 1'b1);
    send_one({5'd31, 6'd20, 5'd8}, 1'b1, 1'b0);
    send_one(16'hFFFF, 1'b0, 1'b0);
    send_one({5'd20, 6'd12, 5'd4}, 1'b0, 1'b1);
    settle();

    // Shrink the frame. Trackers were cleared at 320x240 and keep those start
    // values until the next clear, so the next box must still report them.
    s.frame_width    = 11'd4;
    s.frame_height   = 11'd4;
    s.min_skin_count = '0;
    s.min_box_side   = '0;
    apply_settings(s, 4'hF);
    send_one(16'h0001, 1'b0, 1'b1);
    // A full 4x4 frame of skin plus a partial row past the last one.
    send_frame(18, 100, 1'b1);
    settle();

    // Largest frame, largest box-side threshold and a high skin-count threshold.
    s.frame_width    = 11'd1024;
    s.frame_height   = 11'd1024;
    s.min_skin_count = 19'd262144;
    s.min_box_side   = 10'd1023;
    apply_settings(s, 4'hF);
    send_frame(40, 30, 1'b1);
    settle();

    // Smallest frame: rows past the frame are ignored.
    s.frame_width    = 11'd2;
    s.frame_height   = 11'd2;
    s.min_skin_count = '0;
    s.min_box_side   = '0;
    apply_settings(s, 4'hF);
    send_frame(12, 50, 1'b1);

    // Random phases: new settings for some, all or none of the registers, then a few frames of mixed kinds.
    rand_base = pixels_sent;
    while ((pixels_sent - rand_base) < RANDOM_ITEMS) begin
      settle();
      s.frame_width  = 11'(($urandom_range(0, 9) == 0) ? $urandom_range(2, 1024)
                                                       : $urandom_range(2, 8));
      s.frame_height = 11'(($urandom_range(0, 9) == 0) ? $urandom_range(2, 1024)
                                                       : $urandom_range(2, 8));
      s.min_skin_count = 19'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 262144)
                                                         : $urandom_range(0, 12));
      s.min_box_side   = 10'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                         : $urandom_range(0, 6));
      apply_settings(s, ($urandom_range(0, 4) == 0) ? 4'h0 : 4'($urandom_range(1, 15)));
      fw = int'(tracker.regs.frame_width);
      fh = int'(tracker.regs.frame_height);
      steady_phase = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        roll = $urandom_range(0, 99);
        npix = (fw * fh <= 100) ? fw * fh : $urandom_range(1, 64);
        if (roll < 65) begin
          // Well-formed frame; sometimes cut short, sometimes run past the end.
          tweak = $urandom_range(0, 3);
          if (tweak == 0)
            npix += $urandom_range(1, 16);
          else if (tweak == 1 && npix > 1)
            npix = $urandom_range(1, npix - 1);
          send_frame(npix, $urandom_range(20, 95), 1'b1);
        end else if (roll < 78) begin
          // Burst of one-pixel frames: a box per request, to back up the queue.
          repeat ($urandom_range(1, 8)) send_frame(1, 50, 1'b1);
        end else if (roll < 88) begin
          // Frame with no start mark: relies on the clear after the last box.
          send_frame(npix, $urandom_range(20, 95), 1'b0);
        end else begin
          // Noise: random pixels with stray start and end marks.
          repeat ($urandom_range(1, 30)) begin
            it.pixel       = 16'($urandom);
            it.frame_start = ($urandom_range(0, 9) == 0);
            it.frame_end   = ($urandom_range(0, 7) == 0);
            send_pixel(it);
          end
        end
      end
    end
    steady_phase = 1'b0;

    settle();
    if (tracker.errors == 0)
      $display("tb_skin_region_bounding_box_unit: PASS");
    else
      $display("tb_skin_region_bounding_box_unit: FAIL");
    $finish;
  end

endmodule
